[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the limiter RTL. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// The condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

[sv/plgs_pkg.sv]
// ----------------------------------------------------------------------------
// Peak limiter package
// Types, register codes and constants shared by the limiter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plgs_pkg;

	// Q1.15 unity gain, also the full-scale magnitude.
	localparam logic [15:0] UNITY_GAIN = 16'h8000;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Quotient bits of the target gain division (target stays below unity).
	localparam int DIV_Q_W = 15;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE    = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_ATTACK    = 2'd2,
		REG_RELEASE   = 2'd3
	} cfg_reg_e;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SMOOTH,
		ST_CLAMP,
		ST_SCALE,
		ST_EMIT
	} state_e;

	typedef struct packed {
		logic signed [15:0] sample_in;
		logic               block_end_in;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic [15:0]        gain_now;
		logic               block_end_out;
	} out_item_t;

	// Divider status seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[sv/plgs_div.sv]
// ----------------------------------------------------------------------------
// Target gain divider
// Restoring divider that returns floor(dividend * 2^15 / divisor) one
// quotient bit per cycle. The dividend must be below the divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plgs_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [15:0]                    dividend,
	input  logic [16:0]                    divisor,
	output logic [plgs_pkg::DIV_Q_W-1:0]   quotient,
	output plgs_pkg::div_stat_t            stat
);
	import plgs_pkg::*;

	localparam int CNT_W = $clog2(DIV_Q_W);

	logic [16:0]        rem_q;
	logic [16:0]        divisor_q;
	logic [DIV_Q_W-1:0] quot_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [17:0]        trial;

	// Shift the remainder up one bit and try to take the divisor off.
	assign trial = {rem_q, 1'b0} - {1'b0, divisor_q};

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_Q_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= {1'b0, dividend};
			divisor_q <= divisor;
			quot_q    <= '0;
		end else if (busy_q) begin
			if (!trial[17]) begin
				rem_q  <= trial[16:0];
				quot_q <= {quot_q[DIV_Q_W-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[15:0], 1'b0};
				quot_q <= {quot_q[DIV_Q_W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[sv/peak_limiter_gain_smoother.sv]
// ----------------------------------------------------------------------------
// Peak limiter with attack and release gain smoothing
// Feedforward limiter: per-sample target gain, one-pole smoothing, scaling.
// ----------------------------------------------------------------------------
// One request is handled at a time. A disabled request goes from acceptance
// straight to the result stage; an enabled one whose magnitude is at or
// below the threshold passes the smoothing, clamp and scale states, and one
// above it first waits on the 15-step restoring divider that forms the target
// gain. The smoothing and the output scaling share one 17x17 signed
// multiplier, one use each. A finished result sits in the output register, so
// the next request is accepted while that result still waits to be taken.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module peak_limiter_gain_smoother (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [plgs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [plgs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  plgs_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output plgs_pkg::out_item_t                 out_data
);
	import plgs_pkg::*;

	state_e state_q, state_d;

	logic        enable_q;
	logic [15:0] threshold_q;
	logic [15:0] attack_q;
	logic [15:0] release_q;
	logic [15:0] smooth_q;

	logic signed [15:0] sample_q;
	logic               end_q;
	logic               bypass_q;
	logic               dir_attack_q;
	logic [15:0]        target_q;
	logic [15:0]        gain_q;
	logic signed [33:0] prod_q;

	logic               out_valid_q;
	out_item_t          out_data_q;

	logic               accept;
	logic               div_start;
	logic               emit_load;
	logic [15:0]        thr;
	logic [16:0]        s17;
	logic [16:0]        mag;
	logic [DIV_Q_W-1:0] quotient;
	div_stat_t          div_stat;

	logic               dir_attack;
	logic signed [16:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [18:0] sm_sum;
	logic [15:0]        sm_gain;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			threshold_q <= UNITY_GAIN;
			attack_q    <= '0;
			release_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_ENABLE:    enable_q    <= cfg_wdata[0];
				REG_THRESHOLD: threshold_q <= cfg_wdata;
				REG_ATTACK:    attack_q    <= cfg_wdata;
				REG_RELEASE:   release_q   <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	// Magnitude of the incoming sample and the clipped threshold.
	assign s17 = {in_data.sample_in[15], in_data.sample_in};
	assign mag = in_data.sample_in[15] ? (17'd0 - s17) : s17;
	assign thr = (threshold_q > UNITY_GAIN) ? UNITY_GAIN : threshold_q;

	plgs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (thr),
		.divisor  (mag),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!enable_q)
						state_d = ST_EMIT;
					else if (mag > {1'b0, thr})
						state_d = ST_DIV;
					else
						state_d = ST_SMOOTH;
				end
			end
			ST_DIV: begin
				if (div_stat.done)
					state_d = ST_SMOOTH;
			end
			ST_SMOOTH: state_d = ST_CLAMP;
			ST_CLAMP:  state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Sequencer outputs.
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid && enable_q && (mag > {1'b0, thr});
			end
			ST_EMIT: emit_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	// Shared multiplier operands: smoothing step, then output scaling.
	assign dir_attack = target_q < smooth_q;
	always_comb begin
		if (state_q == ST_SMOOTH) begin
			mul_a = $signed({1'b0, dir_attack ? attack_q : release_q});
			mul_b = $signed({1'b0, smooth_q}) - $signed({1'b0, target_q});
		end else begin
			mul_a = {sample_q[15], sample_q};
			mul_b = $signed({1'b0, gain_q});
		end
	end

	// New gain is target plus the floored coefficient share of the gap.
	assign sm_sum = $signed({3'b000, target_q}) + 19'($signed(prod_q[33:16]));
	always_comb begin
		if (dir_attack_q) begin
			if (sm_sum < $signed({3'b000, target_q}))
				sm_gain = target_q;
			else
				sm_gain = sm_sum[15:0];
		end else begin
			if (sm_sum > $signed({3'b000, UNITY_GAIN}))
				sm_gain = UNITY_GAIN;
			else
				sm_gain = sm_sum[15:0];
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= in_data.sample_in;
			end_q    <= in_data.block_end_in;
			bypass_q <= !enable_q;
			target_q <= UNITY_GAIN;
			gain_q   <= UNITY_GAIN;
		end
		if (state_q == ST_DIV && div_stat.done)
			target_q <= {1'b0, quotient};
		if (state_q == ST_SMOOTH)
			dir_attack_q <= dir_attack;
		if (state_q == ST_CLAMP)
			gain_q <= sm_gain;
		if (state_q == ST_SMOOTH || state_q == ST_SCALE)
			prod_q <= mul_a * mul_b;
	end

	// Stored gain: held at unity while disabled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			smooth_q <= UNITY_GAIN;
		else if (cfg_we && cfg_reg_e'(cfg_index) == REG_ENABLE && !cfg_wdata[0])
			smooth_q <= UNITY_GAIN;
		else if (state_q == ST_CLAMP)
			smooth_q <= sm_gain;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_data_q.sample_out    <= bypass_q ? sample_q : prod_q[30:15];
			out_data_q.gain_now      <= gain_q;
			out_data_q.block_end_out <= end_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The stored gain never rises above unity.
	`ASSERT_NEVER(a_gain_le_unity, clk, arst_n, smooth_q > UNITY_GAIN)
	// While disabled the stored gain sits at unity.
	`ASSERT_NEVER(a_disabled_unity, clk, arst_n, !enable_q && smooth_q != UNITY_GAIN)
	// The divider only reports completion while the sequencer waits on it.
	`ASSERT_NEVER(a_div_done_state, clk, arst_n, div_stat.done && state_q != ST_DIV)
	// The divider only runs while the sequencer waits on it.
	`ASSERT_NEVER(a_div_busy_state, clk, arst_n, div_stat.busy && state_q != ST_DIV)
	// A disabled request goes straight to the result stage.
	`ASSERT_PROP(a_bypass_path, clk, arst_n, (accept && !enable_q) |=> state_q == ST_EMIT)

endmodule

[dv/limiter_checker.sv]
// ----------------------------------------------------------------------------
// Peak limiter checker
// Watches the configuration port and both request channels of the limiter.
// It keeps its own copy of the registers and the smoothed gain, predicts the
// result of every accepted request and compares each accepted result, field
// by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module limiter_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [plgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [plgs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  plgs_pkg::in_item_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  plgs_pkg::out_item_t             out_data,
	output int                              fail_count,
	output int                              outstanding
);

	import plgs_pkg::*;

	// Shadow copy of the registers and the gain state.
	logic        enabled;
	logic [15:0] thresh;
	logic [15:0] attack_c;
	logic [15:0] recover_c;
	logic [15:0] smoothed;

	// Limited samples still waiting to come out of the block.
	out_item_t limited_q[$];

	// Computes the limited sample for one request and advances the gain.
	function automatic out_item_t limit_sample(in_item_t req);
		logic [15:0] raw;
		logic        neg;
		bit [63:0]   mag;
		bit [63:0]   thr;
		bit [63:0]   target;
		bit [63:0]   c;
		bit [63:0]   g;
		bit [63:0]   prod;
		bit [63:0]   q;
		out_item_t   res;
		raw = req.sample_in;
		neg = raw[15];
		mag = neg ? (64'h10000 - raw) : raw;
		thr = (thresh > UNITY_GAIN) ? UNITY_GAIN : thresh;
		res.block_end_out = req.block_end_in;
		if (!enabled) begin
			smoothed = UNITY_GAIN;
			res.sample_out = raw;
			res.gain_now = UNITY_GAIN;
			return res;
		end
		// Target gain: unity at or below the threshold, else thr/mag in Q1.15.
		if (mag <= thr)
			target = UNITY_GAIN;
		else
			target = (thr << 15) / mag;
		g = smoothed;
		if (target < g) begin
			// Attack: move down, never below the target.
			c = attack_c;
			g = (c * g + (64'd65536 - c) * target) >> 16;
			if (g < target)
				g = target;
		end else begin
			// Recovery: move up, never above unity.
			c = recover_c;
			g = (c * g + (64'd65536 - c) * target) >> 16;
			if (g > UNITY_GAIN)
				g = UNITY_GAIN;
		end
		smoothed = g[15:0];
		// Scale the sample; negative values round toward minus infinity.
		prod = mag * g;
		if (neg) begin
			q = (prod + 64'd32767) >> 15;
			res.sample_out = 16'(64'h10000 - q);
		end else begin
			res.sample_out = 16'(prod >> 15);
		end
		res.gain_now = g[15:0];
		return res;
	endfunction

	// Track register writes, predict on each accepted request, check results.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			enabled = 1'b0;
			thresh = UNITY_GAIN;
			attack_c = '0;
			recover_c = '0;
			smoothed = UNITY_GAIN;
			limited_q.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE: begin
						enabled = cfg_wdata[0];
						if (!cfg_wdata[0])
							smoothed = UNITY_GAIN;
					end
					REG_THRESHOLD: thresh = cfg_wdata;
					REG_ATTACK:    attack_c = cfg_wdata;
					REG_RELEASE:   recover_c = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				limited_q.push_back(limit_sample(in_data));
			if (out_valid && out_ready) begin
				if (limited_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result sample %0d gain %0d end %0b",
							$realtime, out_data.sample_out, out_data.gain_now,
							out_data.block_end_out);
				end else begin
					want = limited_q.pop_front();
					if (out_data.sample_out !== want.sample_out ||
						out_data.gain_now !== want.gain_now ||
						out_data.block_end_out !== want.block_end_out) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch sample exp %0d got %0d, gain exp %0d got %0d, end exp %0b got %0b",
								$realtime, want.sample_out, out_data.sample_out,
								want.gain_now, out_data.gain_now,
								want.block_end_out, out_data.block_end_out);
					end
				end
			end
			outstanding = limited_q.size();
		end
	end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Peak limiter testbench
// Drives the limiter with directed corner samples and then with random audio
// under several register settings, with random gaps on both channels and one
// long output stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import plgs_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 150;
	localparam int LONG_HOLD     = 300;
	localparam int HOLD_AT       = 300;
	localparam int DRAIN_CYCLES  = 30;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	int                    fail_count;
	int                    outstanding;
	int                    cycle_count = 0;
	logic                  sender_bursty = 1'b0;
	logic [15:0]           thr_cur = UNITY_GAIN;

	peak_limiter_gain_smoother dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	limiter_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop if the run hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// One register write at the falling edge.
	task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (idx == REG_THRESHOLD)
			thr_cur = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offers one sample request after a random gap and waits for acceptance.
	task automatic push_sample(input logic [15:0] s, input logic e);
		in_item_t item;
		int       gap;
		gap = sender_bursty ? 0 : $urandom_range(0, 4);
		item.sample_in = s;
		item.block_end_in = e;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Drops valid and waits until every result has been taken.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_coeff();
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(60000, 65535));
			default: return 16'($urandom);
		endcase
	endfunction

	// Output side: random stalls, bursts with none, and one long hold-off.
	initial begin
		int stall;
		int taken;
		taken = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ((taken / 40) % 4 == 0) ? 0 : $urandom_range(0, 4);
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			taken++;
			if (taken == HOLD_AT) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int          phase;
		int          n;
		int          mag;
		logic [15:0] s;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Disabled after reset: samples pass through at unity gain.
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h8000, 1'b1);
		push_sample(16'h0000, 1'b0);
		push_sample(16'hFFFF, 1'b1);
		settle();

		// Half-scale threshold with instant attack and recovery.
		write_reg(REG_THRESHOLD, 16'd16384);
		write_reg(REG_ATTACK, 16'd0);
		write_reg(REG_RELEASE, 16'd0);
		write_reg(REG_ENABLE, 16'd1);
		push_sample(16'd16384, 1'b0);
		push_sample(16'd16385, 1'b0);
		push_sample(-16'sd16385, 1'b1);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h7FFF, 1'b1);
		push_sample(16'd1, 1'b0);
		push_sample(16'd0, 1'b0);
		settle();

		// Zero threshold with the slowest smoothing.
		write_reg(REG_THRESHOLD, 16'd0);
		write_reg(REG_ATTACK, 16'hFFFF);
		write_reg(REG_RELEASE, 16'hFFFF);
		push_sample(16'd0, 1'b0);
		push_sample(16'd1, 1'b1);
		push_sample(16'hFFFF, 1'b0);
		push_sample(16'h7FFF, 1'b0);
		settle();

		// Re-enabling keeps the gain; threshold above full scale acts as full scale.
		write_reg(REG_ENABLE, 16'd1);
		write_reg(REG_THRESHOLD, 16'hFFFF);
		push_sample(16'h8000, 1'b1);
		push_sample(16'h7FFF, 1'b0);
		settle();

		// Disabling resets the gain to unity at once.
		write_reg(REG_ENABLE, 16'd0);
		write_reg(REG_ENABLE, 16'd1);
		write_reg(REG_THRESHOLD, 16'd8192);
		push_sample(16'h8000, 1'b0);
		push_sample(16'd100, 1'b1);
		settle();

		// Random audio under a new setting per phase.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 5))
				0: write_reg(REG_THRESHOLD, 16'd0);
				1: write_reg(REG_THRESHOLD, UNITY_GAIN);
				2: write_reg(REG_THRESHOLD, 16'hFFFF);
				3: write_reg(REG_THRESHOLD, 16'($urandom_range(32769, 65535)));
				4: write_reg(REG_THRESHOLD, 16'($urandom_range(1, 8192)));
				default: write_reg(REG_THRESHOLD, 16'($urandom_range(0, 32768)));
			endcase
			write_reg(REG_ATTACK, pick_coeff());
			write_reg(REG_RELEASE, pick_coeff());
			write_reg(REG_ENABLE, (phase == 3) ? 16'd0 : 16'd1);
			sender_bursty = phase[0];
			for (n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 4))
					0: s = 16'($urandom);
					1: begin
						case ($urandom_range(0, 4))
							0: s = 16'h7FFF;
							1: s = 16'h8000;
							2: s = 16'h0000;
							3: s = 16'h0001;
							default: s = 16'hFFFF;
						endcase
					end
					2: begin
						// Near the threshold, either sign.
						mag = ((thr_cur > UNITY_GAIN) ? 32768 : int'(thr_cur))
							+ $urandom_range(0, 8) - 4;
						if (mag < 0)
							mag = 0;
						if (mag > 32767)
							mag = 32767;
						s = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
					end
					3: begin
						// Quiet passage lets the gain recover.
						mag = $urandom_range(0, 255);
						s = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
					end
					default: begin
						// Loud passage drives the gain down.
						mag = $urandom_range(24576, 32768);
						s = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
					end
				endcase
				push_sample(s, 1'($urandom_range(0, 1)));
			end
			settle();
		end
		sender_bursty = 1'b0;

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
